@@ hdl/ppt_pkg.sv @@
// shared types and constants for the periodic priority task dispatcher
package ppt_pkg;

    localparam int MAX_TASKS       = 16;
    localparam int SLOT_W          = $clog2(MAX_TASKS);
    localparam int IDX_W           = $clog2(MAX_TASKS + 1);
    localparam int NEST_DEPTH      = 8;
    localparam int SP_W            = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int DEPTH_W         = 4;
    localparam int PRIO_W          = 8;
    localparam int PRIORITY_LEVELS = 256;
    localparam int TIME_W          = 32;
    localparam int LEVEL_W         = PRIO_W + 1;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int TIU_W           = 5;

    localparam logic [LEVEL_W-1:0] IDLE_LEVEL = LEVEL_W'(255);

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_INIT  = 2'd1;
    localparam logic [1:0] OP_PASS  = 2'd2;
    localparam logic [1:0] OP_DONE  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACK      = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PREEMPT_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TASKS_IN_USE     = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic              pass_ctx;
        logic [TIME_W-1:0] now_ms;
        logic [3:0]        entry_slot;
        logic              entry_enable;
        logic [PRIO_W-1:0] entry_priority;
        logic [TIME_W-1:0] entry_period_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [3:0]        dispatched_slot;
        logic [PRIO_W-1:0] dispatched_priority;
        logic [3:0]        nesting_depth;
    } rsp_t;

    // suspended scan
    typedef struct packed {
        logic [TIME_W-1:0]  now;
        logic               ctx;
        logic [PRIO_W-1:0]  next_prio;
        logic [IDX_W-1:0]   next_idx;
        logic [LEVEL_W-1:0] saved_level;
        logic [SLOT_W-1:0]  slot;
    } frame_t;

    // per-slot view handed to the scan unit
    typedef struct packed {
        logic              enable;
        logic              running;
        logic              preemptive;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] due;
    } slot_info_t;

    // scan control from the sequencer
    typedef struct packed {
        logic               start;
        logic               step;
        logic [TIME_W-1:0]  now;
        logic               ctx;
        logic [PRIO_W-1:0]  cur_p;
        logic [IDX_W-1:0]   cur_i;
        logic [LEVEL_W-1:0] active_level;
    } scan_ctl_t;

endpackage

@@ hdl/periodic_priority_task_dispatcher_unit.sv @@
// top level: sequencer, task table and result register of the dispatcher
//
// Usage: items enter on req (req_valid/req_stall) and each gives exactly one
// result on rsp (rsp_valid/rsp_stall). A transaction completes on a rising edge
// with valid high and stall low. The user writes registers through cfg_wen,
// cfg_index and cfg_data while the block is idle; the block does not check it.
// A slot write or a refused request goes from acceptance to the output stage.
// Initialize sweeps the scanned slots, at most 16; a pass scans them, a done
// item first pops its suspended scan and resumes it, and a dispatch adds a
// dispatch step. The shared scan unit checks one scanned slot per cycle.
// req_stall is high from acceptance until the result is loaded into the output
// register, so one item is in work at a time; a new item may be taken while a
// result still waits.
// Reset clears the task table, running marks, nesting depth and registers,
// and sets the active level to inactive with priority 255. A stalled result
// holds in the output register and the sequencer waits before its next one.
module periodic_priority_task_dispatcher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  ppt_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output ppt_pkg::rsp_t                 rsp,
    input  logic                          cfg_wen,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_POP,
        S_SCAN,
        S_DISP,
        S_OUT
    } state_t;

    state_t                         state_reg;
    logic                           preempt_enable_reg;
    logic [ppt_pkg::PRIO_W-1:0]     priority_ceiling_reg;
    logic [ppt_pkg::TIU_W-1:0]      tasks_in_use_reg;

    logic [ppt_pkg::TIME_W-1:0]     due_reg    [ppt_pkg::MAX_TASKS];
    logic [ppt_pkg::TIME_W-1:0]     period_reg [ppt_pkg::MAX_TASKS];
    logic [ppt_pkg::PRIO_W-1:0]     prio_reg   [ppt_pkg::MAX_TASKS];
    logic [ppt_pkg::MAX_TASKS-1:0]  enable_reg;
    logic [ppt_pkg::MAX_TASKS-1:0]  running_reg;
    logic [ppt_pkg::DEPTH_W-1:0]    depth_reg;
    logic [ppt_pkg::LEVEL_W-1:0]    active_reg;

    logic [ppt_pkg::IDX_W-1:0]      idx_reg;
    logic [ppt_pkg::TIME_W-1:0]     now_reg;
    logic                           ctx_reg;
    logic [ppt_pkg::PRIO_W-1:0]     cur_p_reg;
    logic [ppt_pkg::IDX_W-1:0]      cur_i_reg;

    logic [1:0]                     res_kind_reg;
    logic [3:0]                     res_slot_reg;
    logic [ppt_pkg::PRIO_W-1:0]     res_prio_reg;
    logic                           rsp_valid_reg;
    ppt_pkg::rsp_t                  rsp_reg;

    logic                           accept;
    logic [ppt_pkg::IDX_W-1:0]      count;
    logic [ppt_pkg::SLOT_W-1:0]     cur_slot;
    logic                           idx_live;
    ppt_pkg::scan_ctl_t             scan_ctl;
    ppt_pkg::slot_info_t            slot_info;
    logic                           found;
    logic [ppt_pkg::SLOT_W-1:0]     best_slot;
    logic [ppt_pkg::PRIO_W-1:0]     best_prio;
    logic                           push;
    ppt_pkg::frame_t                push_frame;
    ppt_pkg::frame_t                pop_frame;
    logic [ppt_pkg::SP_W-1:0]       pop_addr;
    logic [ppt_pkg::DEPTH_W-1:0]    depth_less;
    logic                           out_free;

    // handshake and derived control
    always_comb
    begin
        accept    = req_valid && !req_stall;
        count     = (tasks_in_use_reg > ppt_pkg::TIU_W'(ppt_pkg::MAX_TASKS)) ?
                    ppt_pkg::IDX_W'(ppt_pkg::MAX_TASKS) :
                    ppt_pkg::IDX_W'(tasks_in_use_reg);
        cur_slot  = idx_reg[ppt_pkg::SLOT_W-1:0];
        idx_live  = idx_reg < count;
        depth_less = depth_reg - ppt_pkg::DEPTH_W'(1);
        pop_addr  = depth_less[ppt_pkg::SP_W-1:0];
        out_free  = !rsp_valid_reg || !rsp_stall;
    end

    assign req_stall = (state_reg != S_IDLE);

    // view of the slot under the cursor
    always_comb
    begin
        slot_info.enable     = enable_reg[cur_slot];
        slot_info.running    = running_reg[cur_slot];
        slot_info.prio       = prio_reg[cur_slot];
        slot_info.preemptive = preempt_enable_reg && (prio_reg[cur_slot] <= priority_ceiling_reg);
        slot_info.due        = due_reg[cur_slot];
    end

    // scan control
    always_comb
    begin
        scan_ctl.start        = (state_reg == S_POP) ||
                                (accept && req.opcode == ppt_pkg::OP_PASS);
        scan_ctl.step         = (state_reg == S_SCAN) && idx_live;
        scan_ctl.now          = now_reg;
        scan_ctl.ctx          = ctx_reg;
        scan_ctl.cur_p        = cur_p_reg;
        scan_ctl.cur_i        = cur_i_reg;
        scan_ctl.active_level = active_reg;
    end

    // frame pushed on dispatch
    always_comb
    begin
        push                   = (state_reg == S_DISP);
        push_frame.now         = now_reg;
        push_frame.ctx         = ctx_reg;
        push_frame.next_prio   = best_prio;
        push_frame.next_idx    = ppt_pkg::IDX_W'(best_slot) + ppt_pkg::IDX_W'(1);
        push_frame.saved_level = active_reg;
        push_frame.slot        = best_slot;
    end

    ppt_scan_unit u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .idx       (idx_reg),
        .info      (slot_info),
        .found     (found),
        .best_slot (best_slot),
        .best_prio (best_prio)
    );

    ppt_pass_stack u_stack (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (depth_reg[ppt_pkg::SP_W-1:0]),
        .wr_data (push_frame),
        .rd_addr (pop_addr),
        .rd_data (pop_frame)
    );

    // sequencer, task table and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            preempt_enable_reg   <= 1'b0;
            priority_ceiling_reg <= '0;
            tasks_in_use_reg     <= '0;
            for (int i = 0; i < ppt_pkg::MAX_TASKS; i++)
            begin
                due_reg[i]    <= '0;
                period_reg[i] <= '0;
                prio_reg[i]   <= '0;
            end
            enable_reg    <= '0;
            running_reg   <= '0;
            depth_reg     <= '0;
            active_reg    <= ppt_pkg::IDLE_LEVEL;
            idx_reg       <= '0;
            now_reg       <= '0;
            ctx_reg       <= 1'b0;
            cur_p_reg     <= '0;
            cur_i_reg     <= '0;
            res_kind_reg  <= ppt_pkg::KIND_ACK;
            res_slot_reg  <= '0;
            res_prio_reg  <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    ppt_pkg::REG_PREEMPT_ENABLE:   preempt_enable_reg   <= cfg_data[0];
                    ppt_pkg::REG_PRIORITY_CEILING: priority_ceiling_reg <= cfg_data;
                    ppt_pkg::REG_TASKS_IN_USE:
                        tasks_in_use_reg <= cfg_data[ppt_pkg::TIU_W-1:0];
                    default: ;
                endcase
            end

            // result taken and nothing new loaded behind it
            if (rsp_valid_reg && !rsp_stall && state_reg != S_OUT)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg      <= req.now_ms;
                        ctx_reg      <= req.pass_ctx;
                        res_slot_reg <= '0;
                        res_prio_reg <= '0;
                        idx_reg      <= '0;
                        cur_p_reg    <= '0;
                        cur_i_reg    <= '0;
                        unique case (req.opcode)
                            ppt_pkg::OP_WRITE:
                            begin
                                if ({1'b0, req.entry_slot} >= 5'(ppt_pkg::MAX_TASKS))
                                begin
                                    res_kind_reg <= ppt_pkg::KIND_ERROR;
                                end
                                else
                                begin
                                    enable_reg[req.entry_slot[ppt_pkg::SLOT_W-1:0]] <=
                                        req.entry_enable;
                                    prio_reg[req.entry_slot[ppt_pkg::SLOT_W-1:0]] <=
                                        req.entry_priority;
                                    period_reg[req.entry_slot[ppt_pkg::SLOT_W-1:0]] <=
                                        req.entry_period_ms;
                                    res_kind_reg <= ppt_pkg::KIND_ACK;
                                end
                                state_reg <= S_OUT;
                            end
                            ppt_pkg::OP_INIT:
                            begin
                                state_reg <= S_INIT;
                            end
                            ppt_pkg::OP_PASS:
                            begin
                                if (req.pass_ctx && !preempt_enable_reg)
                                begin
                                    res_kind_reg <= ppt_pkg::KIND_FINISHED;
                                    state_reg    <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            ppt_pkg::OP_DONE:
                            begin
                                if (depth_reg == '0)
                                begin
                                    res_kind_reg <= ppt_pkg::KIND_ERROR;
                                    state_reg    <= S_OUT;
                                end
                                else
                                begin
                                    depth_reg <= depth_less;
                                    state_reg <= S_POP;
                                end
                            end
                        endcase
                    end
                end

                // due time sweep over the scanned slots
                S_INIT:
                begin
                    if (idx_live)
                    begin
                        due_reg[cur_slot] <= now_reg;
                        idx_reg           <= idx_reg + ppt_pkg::IDX_W'(1);
                    end
                    else
                    begin
                        running_reg  <= '0;
                        depth_reg    <= '0;
                        active_reg   <= ppt_pkg::IDLE_LEVEL;
                        res_kind_reg <= ppt_pkg::KIND_ACK;
                        state_reg    <= S_OUT;
                    end
                end

                // resume the innermost suspended scan
                S_POP:
                begin
                    running_reg[pop_frame.slot] <= 1'b0;
                    active_reg <= pop_frame.saved_level;
                    now_reg    <= pop_frame.now;
                    ctx_reg    <= pop_frame.ctx;
                    cur_p_reg  <= pop_frame.next_prio;
                    cur_i_reg  <= pop_frame.next_idx;
                    idx_reg    <= '0;
                    state_reg  <= S_SCAN;
                end

                S_SCAN:
                begin
                    if (idx_live)
                    begin
                        idx_reg <= idx_reg + ppt_pkg::IDX_W'(1);
                    end
                    else if (!found)
                    begin
                        res_kind_reg <= ppt_pkg::KIND_FINISHED;
                        state_reg    <= S_OUT;
                    end
                    else if (depth_reg >= ppt_pkg::DEPTH_W'(ppt_pkg::NEST_DEPTH))
                    begin
                        res_kind_reg <= ppt_pkg::KIND_ERROR;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= ppt_pkg::IDX_W'(best_slot);
                        state_reg <= S_DISP;
                    end
                end

                // dispatch the chosen task
                S_DISP:
                begin
                    due_reg[cur_slot]     <= now_reg + period_reg[cur_slot];
                    running_reg[cur_slot] <= 1'b1;
                    depth_reg    <= depth_reg + ppt_pkg::DEPTH_W'(1);
                    active_reg   <= {1'b1, best_prio};
                    res_kind_reg <= ppt_pkg::KIND_DISPATCH;
                    res_slot_reg <= 4'(best_slot);
                    res_prio_reg <= best_prio;
                    state_reg    <= S_OUT;
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        rsp_reg.result_kind         <= res_kind_reg;
                        rsp_reg.dispatched_slot     <= res_slot_reg;
                        rsp_reg.dispatched_priority <= res_prio_reg;
                        rsp_reg.nesting_depth       <= 4'(depth_reg);
                        rsp_valid_reg               <= 1'b1;
                        state_reg                   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // nesting never goes past the stack size
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= ppt_pkg::DEPTH_W'(ppt_pkg::NEST_DEPTH))
        else $error("nesting depth beyond stack size");

    // a dispatch always leaves a callback outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.result_kind == ppt_pkg::KIND_DISPATCH) |-> rsp.nesting_depth != '0)
        else $error("dispatch reported with no outstanding callback");

    // an accepted transaction keeps the input closed on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> req_stall)
        else $error("input open while a transaction is in work");

    // a dispatched task is marked running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISP) |=> running_reg[$past(cur_slot)])
        else $error("dispatched task not marked running");

endmodule

@@ hdl/ppt_scan_unit.sv @@
// slot evaluator: checks one slot a cycle and keeps the best candidate
module ppt_scan_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ppt_pkg::scan_ctl_t        ctl,
    input  logic [ppt_pkg::IDX_W-1:0] idx,
    input  ppt_pkg::slot_info_t       info,
    output logic                      found,
    output logic [ppt_pkg::SLOT_W-1:0] best_slot,
    output logic [ppt_pkg::PRIO_W-1:0] best_prio
);

    logic                        found_reg;
    logic [ppt_pkg::SLOT_W-1:0]  best_slot_reg;
    logic [ppt_pkg::PRIO_W-1:0]  best_prio_reg;
    logic [ppt_pkg::TIME_W-1:0]  diff;
    logic                        due_ok;
    logic                        can_run;
    logic                        past_cursor;
    logic                        in_levels;
    logic                        eligible;
    logic                        better;

    // wrap-safe due check and eligibility of the current slot
    always_comb
    begin
        diff        = ctl.now - info.due;
        due_ok      = ~diff[ppt_pkg::TIME_W-1];
        can_run     = ~ctl.active_level[ppt_pkg::LEVEL_W-1] ||
                      (info.prio < ctl.active_level[ppt_pkg::PRIO_W-1:0]);
        past_cursor = {info.prio, idx} >= {ctl.cur_p, ctl.cur_i};
        in_levels   = {1'b0, info.prio} < (ppt_pkg::PRIO_W+1)'(ppt_pkg::PRIORITY_LEVELS);
        eligible    = info.enable && !info.running && (info.preemptive == ctl.ctx) &&
                      due_ok && can_run && past_cursor && in_levels;
        better      = !found_reg || (info.prio < best_prio_reg);
    end

    // best candidate, priority first then lowest slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.step && eligible && better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && eligible && better)
        begin
            best_slot_reg <= idx[ppt_pkg::SLOT_W-1:0];
            best_prio_reg <= info.prio;
        end
    end

    assign found     = found_reg;
    assign best_slot = best_slot_reg;
    assign best_prio = best_prio_reg;

endmodule

@@ hdl/ppt_pass_stack.sv @@
// memory of suspended scans, one write and one registered read a cycle
module ppt_pass_stack (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ppt_pkg::SP_W-1:0] wr_addr,
    input  ppt_pkg::frame_t          wr_data,
    input  logic [ppt_pkg::SP_W-1:0] rd_addr,
    output ppt_pkg::frame_t          rd_data
);

    ppt_pkg::frame_t mem [ppt_pkg::NEST_DEPTH];
    ppt_pkg::frame_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
